@@ design/matrix_vector_multiply_6x6_macros.svh @@
// Assertion macros for the 6x6 matrix-vector multiplier
`ifndef MATRIX_VECTOR_MULTIPLY_6X6_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_6X6_MACROS_SVH

// same-cycle implication, checked out of reset
`define MVM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mvm6_pkg.sv @@
// Package: constants, microcode types and control store for the 6x6 multiplier
package mvm6_pkg;

  localparam int DIM     = 6;
  localparam int ENTRIES = DIM * DIM;
  localparam int IDX_W   = $clog2(DIM);
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int DW      = 32;
  localparam int FRAC    = 16;
  localparam int PROD_W  = 2 * DW;
  localparam int ACC_W   = PROD_W + 2;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_IDENT = 2'd1;
  localparam logic [1:0] OP_MUL   = 2'd2;

  // microprogram steps
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_DIAG   = 3'd1;
  localparam step_t STEP_MAC    = 3'd2;
  localparam step_t STEP_DRAIN0 = 3'd3;
  localparam step_t STEP_DRAIN1 = 3'd4;
  localparam step_t STEP_PUB    = 3'd5;

  // jump conditions: jump when true, otherwise hold the step
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_LAST_DIAG,
    C_LAST_MAC,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  diag;
    logic  mac;
    logic  publish;
    cond_t cond;
    step_t target;
  } ctl_t;

  function automatic ctl_t uc_rom(input step_t step);
    ctl_t w;
    w = '{accept: 1'b0, diag: 1'b0, mac: 1'b0, publish: 1'b0,
          cond: C_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond   = C_DISPATCH;
      end
      STEP_DIAG: begin
        w.diag   = 1'b1;
        w.cond   = C_LAST_DIAG;
        w.target = STEP_IDLE;
      end
      STEP_MAC: begin
        w.mac    = 1'b1;
        w.cond   = C_LAST_MAC;
        w.target = STEP_DRAIN0;
      end
      STEP_DRAIN0: begin
        w.target = STEP_DRAIN1;
      end
      STEP_DRAIN1: begin
        w.target = STEP_PUB;
      end
      STEP_PUB: begin
        w.publish = 1'b1;
        w.cond    = C_OUT_FREE;
        w.target  = STEP_IDLE;
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // entry step for each operation code
  function automatic step_t op_dispatch(input logic [1:0] op);
    step_t s;
    unique case (op)
      OP_IDENT: s = STEP_DIAG;
      OP_MUL:   s = STEP_MAC;
      default:  s = STEP_IDLE;
    endcase
    return s;
  endfunction

  // row-major address: row*6 + col
  function automatic logic [ADDR_W-1:0] ent_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(DIM) + ADDR_W'(c);
  endfunction

endpackage

@@ design/matrix_vector_multiply_6x6.sv @@
// Top level: microcoded 6x6 Q16.16 matrix store and matrix-vector multiplier
//
//   channel | ports                                   | role
//   --------+-----------------------------------------+---------------------------
//   in      | in_valid/in_ready, operation,row,col,   | write, identity or multiply
//           | value, vec_0..vec_5                     |
//   out     | out_valid/out_ready, res_0..res_5,      | one beat per multiply
//           | saturated                               |
//
// Write: done as the beat is accepted. Identity: valid bits cleared at once, then one
// diagonal write a cycle through the single memory write port. Multiply: the one
// 32x32 multiplier does all 36 MACs through a 3-deep read/multiply/accumulate
// pipeline, then the DRAIN0, DRAIN1 and PUB steps. Synchronous active-low reset
// clears control and the per-entry valid bits (the matrix reads as zero). A stalled
// result sits in the output register while the next beat is taken; only a second
// multiply's publish step waits for it.
`include "matrix_vector_multiply_6x6_macros.svh"

module matrix_vector_multiply_6x6
  import mvm6_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic [2:0]           in_row,
  input  logic [2:0]           in_col,
  input  logic signed [DW-1:0] in_value,
  input  logic signed [DW-1:0] in_vec_0,
  input  logic signed [DW-1:0] in_vec_1,
  input  logic signed [DW-1:0] in_vec_2,
  input  logic signed [DW-1:0] in_vec_3,
  input  logic signed [DW-1:0] in_vec_4,
  input  logic signed [DW-1:0] in_vec_5,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_res_0,
  output logic signed [DW-1:0] out_res_1,
  output logic signed [DW-1:0] out_res_2,
  output logic signed [DW-1:0] out_res_3,
  output logic signed [DW-1:0] out_res_4,
  output logic signed [DW-1:0] out_res_5,
  output logic                 out_saturated
);

  // ---- sequencer ----
  step_t pc_r, pc_nxt;
  ctl_t  ctl;
  logic  in_acc;
  logic  cond_ok;

  logic [IDX_W-1:0] i_r, i_nxt;   // row counter (also diagonal index)
  logic [IDX_W-1:0] k_r, k_nxt;   // column counter

  logic                 out_valid_r;
  logic                 last_mac;
  logic                 last_diag;

  assign ctl       = uc_rom(pc_r);
  assign in_ready  = ctl.accept;
  assign in_acc    = in_valid && ctl.accept;
  assign last_diag = (i_r == IDX_W'(DIM - 1));
  assign last_mac  = last_diag && (k_r == IDX_W'(DIM - 1));

  always_comb begin
    cond_ok = 1'b0;
    unique case (ctl.cond)
      C_ALWAYS:    cond_ok = 1'b1;
      C_DISPATCH:  cond_ok = in_acc;
      C_LAST_DIAG: cond_ok = last_diag;
      C_LAST_MAC:  cond_ok = last_mac;
      C_OUT_FREE:  cond_ok = !out_valid_r || out_ready;
      default:     cond_ok = 1'b1;
    endcase

    pc_nxt = pc_r;
    if (cond_ok) begin
      pc_nxt = (ctl.cond == C_DISPATCH) ? op_dispatch(in_operation) : ctl.target;
    end

    i_nxt = i_r;
    k_nxt = k_r;
    if (in_acc) begin
      i_nxt = '0;
      k_nxt = '0;
    end else if (ctl.diag) begin
      i_nxt = i_r + 1'b1;
    end else if (ctl.mac) begin
      if (k_r == IDX_W'(DIM - 1)) begin
        k_nxt = '0;
        i_nxt = i_r + 1'b1;
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    k_r <= k_nxt;
  end

  // ---- operand capture ----
  logic signed [DW-1:0] gain_r;
  logic signed [DW-1:0] vec_r [DIM];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gain_r   <= in_value;
      vec_r[0] <= in_vec_0;
      vec_r[1] <= in_vec_1;
      vec_r[2] <= in_vec_2;
      vec_r[3] <= in_vec_3;
      vec_r[4] <= in_vec_4;
      vec_r[5] <= in_vec_5;
    end
  end

  // ---- matrix memory, one write and one registered read a cycle ----
  logic [DW-1:0]     matrix_mem [ENTRIES];
  logic [ENTRIES-1:0] ent_v_r;      // entry written since reset/identity load
  logic              mem_we;
  logic              clr_all;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [DW-1:0]     wr_data;
  logic [DW-1:0]     rd_q_r;
  logic              rd_v_r;

  assign clr_all = in_acc && (in_operation == OP_IDENT);
  assign mem_we  = ctl.diag ||
                   (in_acc && (in_operation == OP_WRITE) &&
                    (in_row < IDX_W'(DIM)) && (in_col < IDX_W'(DIM)));
  assign wr_addr = ctl.diag ? ent_addr(i_r, i_r) : ent_addr(in_row, in_col);
  assign wr_data = ctl.diag ? gain_r : in_value;
  assign rd_addr = ent_addr(i_r, k_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      matrix_mem[wr_addr] <= wr_data;
    end
    rd_q_r <= matrix_mem[rd_addr];
    rd_v_r <= ent_v_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= '0;
    end else if (clr_all) begin
      ent_v_r <= '0;
    end else if (mem_we) begin
      ent_v_r[wr_addr] <= 1'b1;
    end
  end

  // ---- MAC pipeline: read -> multiply -> accumulate/saturate ----
  logic             s1_v_r, s1_first_r, s1_last_r;
  logic [IDX_W-1:0] s1_i_r, s1_k_r;
  logic             s2_v_r, s2_first_r, s2_last_r;
  logic [IDX_W-1:0] s2_i_r;

  logic signed [DW-1:0]     mul_a;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  sum_sh;
  logic [ACC_W-DW:0]        sum_hi;
  logic                     fits;
  logic [DW-1:0]            sat_val;
  logic [DW-1:0]            res_r [DIM];
  logic                     sat_r;

  assign mul_a = rd_v_r ? $signed(rd_q_r) : '0;   // unwritten entries read as zero

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= ctl.mac;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_i_r     <= i_r;
    s1_k_r     <= k_r;
    s1_first_r <= (k_r == '0);
    s1_last_r  <= (k_r == IDX_W'(DIM - 1));
    s2_i_r     <= s1_i_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= mul_a * vec_r[s1_k_r];
  end

  always_comb begin
    sum     = (s2_first_r ? '0 : acc_r) +
              $signed({{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r});
    sum_sh  = sum >>> FRAC;
    sum_hi  = sum_sh[ACC_W-1:DW-1];
    fits    = (&sum_hi) || !(|sum_hi);
    sat_val = fits ? sum_sh[DW-1:0]
                   : {sum_sh[ACC_W-1], {(DW-1){!sum_sh[ACC_W-1]}}};
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sat_r <= 1'b0;
    end else if (s2_v_r && s2_last_r && !fits) begin
      sat_r <= 1'b1;
    end
    if (s2_v_r) begin
      acc_r <= sum;
      if (s2_last_r) begin
        res_r[s2_i_r] <= sat_val;
      end
    end
  end

  // ---- output register ----
  logic [DW-1:0] out_res_r [DIM];
  logic          out_sat_r;
  logic          pub_fire;

  assign pub_fire = ctl.publish && cond_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pub_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pub_fire) begin
      out_res_r <= res_r;
      out_sat_r <= sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_saturated = out_sat_r;
  assign out_res_0     = $signed(out_res_r[0]);
  assign out_res_1     = $signed(out_res_r[1]);
  assign out_res_2     = $signed(out_res_r[2]);
  assign out_res_3     = $signed(out_res_r[3]);
  assign out_res_4     = $signed(out_res_r[4]);
  assign out_res_5     = $signed(out_res_r[5]);

  // ---- assertions ----
  `MVM_ASSERT_NOW(a_idle_drained, in_ready, !s1_v_r && !s2_v_r, "beat taken with MACs in flight")
  `MVM_ASSERT_NOW(a_pub_drained, ctl.publish, !s1_v_r && !s2_v_r, "publish before pipeline drained")
  `MVM_ASSERT_NEXT(a_mul_start, in_acc && (in_operation == OP_MUL), (pc_r == STEP_MAC) && (i_r == '0) && (k_r == '0), "multiply did not start at entry zero")
  `MVM_ASSERT_NOW(a_no_wr_in_mac, ctl.mac, !mem_we, "matrix written during multiply")

endmodule

@@ dv/tb_top.sv @@
// Testbench for the 6x6 Q16.16 matrix-vector multiplier: directed and random checks
`timescale 1ns / 1ps

module tb_top
  import mvm6_pkg::*;
();

  // Code 3 has no package name; the block must treat it as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Saturation bounds, held at accumulator width so the compares stay signed.
  localparam logic signed [71:0] Q_MAX = 72'sh0000_0000_7FFF_FFFF;
  localparam logic signed [71:0] Q_MIN = -72'sh0000_0000_8000_0000;

  typedef logic [DIM-1:0][DW-1:0] vec_t;

  typedef struct packed {
    vec_t res;
    logic saturated;
  } product_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_operation = OP_WRITE;
  logic [2:0]           in_row = '0;
  logic [2:0]           in_col = '0;
  logic signed [DW-1:0] in_value = '0;
  logic signed [DW-1:0] in_vec_0 = '0;
  logic signed [DW-1:0] in_vec_1 = '0;
  logic signed [DW-1:0] in_vec_2 = '0;
  logic signed [DW-1:0] in_vec_3 = '0;
  logic signed [DW-1:0] in_vec_4 = '0;
  logic signed [DW-1:0] in_vec_5 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic signed [DW-1:0] out_res_0;
  logic signed [DW-1:0] out_res_1;
  logic signed [DW-1:0] out_res_2;
  logic signed [DW-1:0] out_res_3;
  logic signed [DW-1:0] out_res_4;
  logic signed [DW-1:0] out_res_5;
  logic                 out_saturated;

  matrix_vector_multiply_6x6 dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_value     (in_value),
    .in_vec_0     (in_vec_0),
    .in_vec_1     (in_vec_1),
    .in_vec_2     (in_vec_2),
    .in_vec_3     (in_vec_3),
    .in_vec_4     (in_vec_4),
    .in_vec_5     (in_vec_5),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res_0    (out_res_0),
    .out_res_1    (out_res_1),
    .out_res_2    (out_res_2),
    .out_res_3    (out_res_3),
    .out_res_4    (out_res_4),
    .out_res_5    (out_res_5),
    .out_saturated(out_saturated)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Testbench copy of the matrix, row-major, cleared as the block is at reset.
  logic signed [DW-1:0] shadow_matrix [ENTRIES];
  product_t             expected_products [$];
  int unsigned          applied_items = 0;
  int unsigned          fail_count = 0;

  // Sender burst state: beats left in this burst before the next gap.
  int unsigned          burst_left = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) shadow_matrix[i] = '0;
  end

  // Row by row: exact sum of six 64-bit products, arithmetic shift right by the
  // fraction bits (floor), then clip to 32 bits. Any clip raises the flag.
  function automatic product_t matrix_times_vector(input vec_t vec);
    product_t          p;
    logic signed [63:0] prod;
    logic signed [71:0] acc;
    logic signed [71:0] scaled;
    p.saturated = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int c = 0; c < DIM; c++) begin
        prod = $signed(shadow_matrix[r * DIM + c]) * $signed(vec[c]);
        acc  = acc + prod;
      end
      scaled = acc >>> FRAC;
      if (scaled > Q_MAX) begin
        p.res[r]    = Q_MAX[DW-1:0];
        p.saturated = 1'b1;
      end else if (scaled < Q_MIN) begin
        p.res[r]    = Q_MIN[DW-1:0];
        p.saturated = 1'b1;
      end else begin
        p.res[r] = scaled[DW-1:0];
      end
    end
    return p;
  endfunction

  // Applies one accepted beat to the shadow matrix; multiplies queue a product.
  task automatic apply_beat(input logic [1:0] op, input logic [2:0] row,
                            input logic [2:0] col, input logic [DW-1:0] value,
                            input vec_t vec);
    case (op)
      OP_WRITE: begin
        // out-of-range positions are dropped by the block
        if (row < DIM && col < DIM) begin
          shadow_matrix[row * DIM + col] = value;
          applied_items++;
        end
      end
      OP_IDENT: begin
        for (int i = 0; i < ENTRIES; i++)
          shadow_matrix[i] = (i / DIM == i % DIM) ? value : '0;
        applied_items++;
      end
      OP_MUL: begin
        expected_products.push_back(matrix_times_vector(vec));
        applied_items++;
      end
      default: ;
    endcase
  endtask

  // Drives one beat from a falling edge, holds it until accepted, and returns
  // on the next falling edge. Valid stays high across a burst; between bursts
  // it drops for a random gap so gaps land on every step of a multiply.
  task automatic send_item(input logic [1:0] op, input logic [2:0] row,
                           input logic [2:0] col, input logic [DW-1:0] value,
                           input vec_t vec);
    int unsigned gap;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 50) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
    end
    burst_left--;
    in_operation = op;
    in_row       = row;
    in_col       = col;
    in_value     = value;
    in_vec_0     = vec[0];
    in_vec_1     = vec[1];
    in_vec_2     = vec[2];
    in_vec_3     = vec[3];
    in_vec_4     = vec[4];
    in_vec_5     = vec[5];
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_beat(op, row, col, value, vec);
    @(negedge clk);
  endtask

  function automatic vec_t make_vec(input logic [DW-1:0] v0, input logic [DW-1:0] v1,
                                    input logic [DW-1:0] v2, input logic [DW-1:0] v3,
                                    input logic [DW-1:0] v4, input logic [DW-1:0] v5);
    return {v5, v4, v3, v2, v1, v0};
  endfunction

  // Q16.16 value: mostly moderate magnitudes so results stay in range, with
  // full-scale words and hand-picked corners mixed in to hit saturation.
  function automatic logic [DW-1:0] rand_q16();
    logic [DW-1:0] w;
    case ($urandom_range(0, 7))
      0, 1: w = $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0: w = 32'h7FFF_FFFF;
          1: w = 32'h8000_0000;
          2: w = 32'h0000_0000;
          3: w = 32'hFFFF_FFFF;
          4: w = 32'h0001_0000;
          default: w = 32'hFFFF_0000;
        endcase
      end
      3: w = 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: w = 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    endcase
    return w;
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    for (int i = 0; i < DIM; i++) v[i] = rand_q16();
    return v;
  endfunction

  // Receiver: swaps between always ready, scattered stalls and long holds,
  // each mode lasting a random stretch of cycles.
  int unsigned stall_mode = 0;
  int unsigned mode_cycles = 0;
  int unsigned hold_cycles = 0;

  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  = $urandom_range(0, 2);
      mode_cycles = $urandom_range(50, 400);
    end
    mode_cycles--;
    if (hold_cycles != 0) begin
      hold_cycles--;
      out_ready = 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            hold_cycles = $urandom_range(5, 60);
            out_ready   = 1'b0;
          end else begin
            out_ready = 1'b1;
          end
        end
      endcase
    end
  end

  // Result check: every accepted result beat against the oldest product.
  always @(posedge clk) begin : check_results
    product_t want;
    vec_t     got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_res_5, out_res_4, out_res_3, out_res_2, out_res_1, out_res_0};
      if (expected_products.size() == 0) begin
        $error("result beat with no multiply outstanding");
        fail_count++;
      end else begin
        want = expected_products.pop_front();
        for (int i = 0; i < DIM; i++) begin
          if (got[i] !== want.res[i]) begin
            $error("res_%0d: expected %0d, got %0d", i, $signed(want.res[i]),
                   $signed(got[i]));
            fail_count++;
          end
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_saturated);
          fail_count++;
        end
      end
    end
  end

  // A freshly reset matrix multiplies anything to zero.
  task automatic test_cleared_matrix();
    send_item(OP_MUL, 3'd0, 3'd0, '0,
              make_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                       32'h0001_0000, 32'hFFFF_0000));
  endtask

  // Identity with unit gain passes the vector straight through.
  task automatic test_unit_identity();
    send_item(OP_IDENT, 3'd7, 3'd7, 32'h0001_0000, rand_vec());
    send_item(OP_MUL, 3'd0, 3'd0, '0,
              make_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                       32'h0001_0000, 32'h0000_0001));
  endtask

  // Largest and most negative gains: clipping both ways, no-clip rows beside
  // clipped ones, and floor rounding of a small negative product.
  task automatic test_gain_extremes();
    send_item(OP_IDENT, 3'd0, 3'd0, 32'h7FFF_FFFF, rand_vec());
    send_item(OP_MUL, 3'd0, 3'd0, '0,
              make_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
                       32'h0000_0001, 32'hFFFF_FFFF));
    send_item(OP_IDENT, 3'd5, 3'd2, 32'h8000_0000, rand_vec());
    send_item(OP_MUL, 3'd0, 3'd0, '0,
              make_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0,
                       32'h0000_0001, 32'hFFFF_FFFF));
  endtask

  // Single-entry writes at the corners of the matrix, an overwrite of the
  // same entry, and a row whose products cancel.
  task automatic test_entry_writes();
    send_item(OP_IDENT, 3'd0, 3'd0, 32'h0, rand_vec());
    send_item(OP_WRITE, 3'd0, 3'd5, 32'hFFFF_FFFF, rand_vec());
    send_item(OP_WRITE, 3'd5, 3'd0, 32'h7FFF_FFFF, rand_vec());
    send_item(OP_WRITE, 3'd2, 3'd3, 32'h8000_0000, rand_vec());
    send_item(OP_WRITE, 3'd2, 3'd3, 32'h0001_8000, rand_vec());
    send_item(OP_WRITE, 3'd2, 3'd4, 32'hFFFE_8000, rand_vec());
    send_item(OP_MUL, 3'd0, 3'd0, '0,
              make_vec(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0001_0000,
                       32'h0001_0000, 32'h0000_0001));
  endtask

  // Out-of-range positions and the unused code must leave the matrix alone.
  task automatic test_ignored_items();
    send_item(OP_WRITE, 3'd6, 3'd0, 32'h1234_5678, rand_vec());
    send_item(OP_WRITE, 3'd0, 3'd7, 32'h1234_5678, rand_vec());
    send_item(OP_WRITE, 3'd7, 3'd6, 32'h8765_4321, rand_vec());
    send_item(OP_UNUSED, 3'd1, 3'd1, 32'h7FFF_FFFF, rand_vec());
    send_item(OP_MUL, 3'd0, 3'd0, '0,
              make_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                       32'h0001_0000, 32'h0001_0000));
  endtask

  // Mostly well-formed sequences (optional identity, a few entry writes, then
  // multiplies); the rest are single beats with any code and any position.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned target;
    int unsigned n;
    target = applied_items + n_items;
    while (applied_items < target) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1) != 0)
          send_item(OP_IDENT, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    rand_q16(), rand_vec());
        n = $urandom_range(0, 8);
        repeat (n)
          send_item(OP_WRITE, 3'($urandom_range(0, 5)), 3'($urandom_range(0, 5)),
                    rand_q16(), rand_vec());
        n = $urandom_range(1, 3);
        repeat (n)
          send_item(OP_MUL, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    $urandom, rand_vec());
      end else begin
        send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), rand_q16(), rand_vec());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_cleared_matrix();
    test_unit_identity();
    test_gain_extremes();
    test_entry_writes();
    test_ignored_items();
    test_random_traffic(800);

    in_valid = 1'b0;
    // drain: all products back, then a margin longer than one multiply
    while (expected_products.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ matrix_vector_multiply_6x6.f @@
+incdir+design
design/mvm6_pkg.sv
design/matrix_vector_multiply_6x6.sv
dv/tb_top.sv
